/* hw/rtl/rnpc_pkg.sv */
// ----------------------------------------------------------------------------
// rnpc_pkg
// Types and constants shared by the name percent-escape codec modules.
// ----------------------------------------------------------------------------
package rnpc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_PCT  = 8'h25;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_name;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_name;
  } out_item_t;

  // One accepted item, expanded into its ordered list of results.
  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] slot;
    logic [SLOT_W-1:0]           last_idx;
  } cmd_t;

endpackage

/* hw/rtl/room_name_percent_codec.sv */
// The first result of an input beat passes through the command queue and then the output
// register of the back end before it reaches the result ports.
// Throughput: one result beat per cycle while the receiver keeps popping, set by the single
// output register of the back end. An input beat that expands to k results occupies the
// back end until all k are loaded; the queue absorbs short bursts before full is raised.
// Reset clears the queue and output register, selects encode mode and starts a new name.
// ----------------------------------------------------------------------------
// room_name_percent_codec
// Streaming percent-escape encoder and decoder for names, one byte per beat.
// ----------------------------------------------------------------------------
module room_name_percent_codec #(
  parameter int unsigned QueueDepth = rnpc_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic                push,
  output logic                full,
  input  rnpc_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output rnpc_pkg::out_item_t out_item_o
);

  logic           accept;
  logic           cmd_push, cmd_pop, cmd_valid;
  rnpc_pkg::cmd_t cmd_in, cmd_head;

  assign accept = push && !full;

  rnpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  rnpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_head)
  );

  rnpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule

/* hw/rtl/rnpc_front.sv */
// ----------------------------------------------------------------------------
// rnpc_front
// Accepts input beats, tracks the escape state and builds the result list.
// ----------------------------------------------------------------------------
module rnpc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               accept_i,
  input  rnpc_pkg::in_item_t item_i,
  output logic               cmd_push_o,
  output rnpc_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HEX  = 3'b100
  } esc_e;

  localparam int unsigned CntW = $clog2(rnpc_pkg::MAX_RESULTS + 1);

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
    end else begin
      v = c - 8'h61 + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h41 + {4'h0, n} - 8'd10);
  endfunction

  function automatic rnpc_pkg::out_item_t chr(input logic [7:0] c);
    rnpc_pkg::out_item_t r;
    r.out_byte     = c;
    r.byte_valid   = 1'b1;
    r.last_of_name = 1'b0;
    return r;
  endfunction

  logic       mode_q;
  logic       at_start_q, at_start_d;
  esc_e       esc_q, esc_d;
  logic [7:0] held_q, held_d;

  rnpc_pkg::out_item_t [rnpc_pkg::MAX_RESULTS-1:0] res;
  logic [CntW-1:0] n;
  logic            plain;
  logic [7:0]      b;

  assign b = item_i.in_byte;

  always_comb begin
    res        = '0;
    n          = '0;
    plain      = 1'b0;
    at_start_d = at_start_q;
    esc_d      = esc_q;
    held_d     = held_q;
    if (item_i.end_of_name) begin
      if (mode_q == rnpc_pkg::MODE_DECODE) begin
        if (esc_q == ESC_PCT) begin
          res[n[rnpc_pkg::SLOT_W-1:0]] = chr(rnpc_pkg::CH_PCT); n = n + 1'b1;
        end else if (esc_q == ESC_HEX) begin
          res[n[rnpc_pkg::SLOT_W-1:0]] = chr(rnpc_pkg::CH_PCT); n = n + 1'b1;
          res[n[rnpc_pkg::SLOT_W-1:0]] = chr(held_q);           n = n + 1'b1;
        end
      end
      res[n[rnpc_pkg::SLOT_W-1:0]] = '{out_byte: 8'h00, byte_valid: 1'b0,
                                        last_of_name: 1'b1};
      n          = n + 1'b1;
      at_start_d = 1'b1;
      esc_d      = ESC_NONE;
      held_d     = 8'h00;
    end else if (mode_q == rnpc_pkg::MODE_ENCODE) begin
      if (at_start_q) begin
        res[n[rnpc_pkg::SLOT_W-1:0]] = chr(rnpc_pkg::CH_HASH); n = n + 1'b1;
        at_start_d = 1'b0;
      end
      if (is_alnum(b)) begin
        res[n[rnpc_pkg::SLOT_W-1:0]] = chr(b); n = n + 1'b1;
      end else begin
        res[n[rnpc_pkg::SLOT_W-1:0]] = chr(rnpc_pkg::CH_PCT); n = n + 1'b1;
        res[n[rnpc_pkg::SLOT_W-1:0]] = chr(hex_char(b[7:4])); n = n + 1'b1;
        res[n[rnpc_pkg::SLOT_W-1:0]] = chr(hex_char(b[3:0])); n = n + 1'b1;
      end
    end else begin
      at_start_d = 1'b0;
      // A leading '#' of a name is dropped and produces no result.
      if (!(at_start_q && b == rnpc_pkg::CH_HASH)) begin
        unique case (esc_q)
          ESC_PCT: begin
            if (is_hex(b)) begin
              held_d = b;
              esc_d  = ESC_HEX;
            end else begin
              res[n[rnpc_pkg::SLOT_W-1:0]] = chr(rnpc_pkg::CH_PCT); n = n + 1'b1;
              esc_d = ESC_NONE;
              plain = 1'b1;
            end
          end
          ESC_HEX: begin
            if (is_hex(b)) begin
              res[n[rnpc_pkg::SLOT_W-1:0]] = chr({hex_nib(held_q), hex_nib(b)});
              n = n + 1'b1;
            end else begin
              res[n[rnpc_pkg::SLOT_W-1:0]] = chr(rnpc_pkg::CH_PCT); n = n + 1'b1;
              res[n[rnpc_pkg::SLOT_W-1:0]] = chr(held_q);           n = n + 1'b1;
              plain = 1'b1;
            end
            esc_d  = ESC_NONE;
            held_d = 8'h00;
          end
          default: begin
            esc_d = ESC_NONE;
            plain = 1'b1;
          end
        endcase
        if (plain) begin
          if (b == rnpc_pkg::CH_PCT) begin
            esc_d = ESC_PCT;
          end else begin
            res[n[rnpc_pkg::SLOT_W-1:0]] = chr(b); n = n + 1'b1;
          end
        end
      end
    end
  end

  assign cmd_push_o     = accept_i && (n != '0);
  assign cmd_o.slot     = res;
  assign cmd_o.last_idx = n[rnpc_pkg::SLOT_W-1:0] - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= rnpc_pkg::MODE_ENCODE;
      at_start_q <= 1'b1;
      esc_q      <= ESC_NONE;
      held_q     <= 8'h00;
    end else if (cfg_we_i) begin
      mode_q     <= cfg_data_i;
      at_start_q <= 1'b1;
      esc_q      <= ESC_NONE;
      held_q     <= 8'h00;
    end else if (accept_i) begin
      at_start_q <= at_start_d;
      esc_q      <= esc_d;
      held_q     <= held_d;
    end
  end

endmodule

/* hw/rtl/rnpc_queue.sv */
// ----------------------------------------------------------------------------
// rnpc_queue
// Small first-in first-out queue of expanded commands between front and back.
// ----------------------------------------------------------------------------
module rnpc_queue #(
  parameter int unsigned Depth = rnpc_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rnpc_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rnpc_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rnpc_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= next_ptr(wr_q);
      end
      if (do_pop) begin
        rd_q <= next_ptr(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/rnpc_back.sv */
// ----------------------------------------------------------------------------
// rnpc_back
// Walks the result list of the head command into the output register.
// ----------------------------------------------------------------------------
module rnpc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  rnpc_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output rnpc_pkg::out_item_t out_item_o
);

  logic [rnpc_pkg::SLOT_W-1:0] idx_q;
  logic                        out_valid_q;
  rnpc_pkg::out_item_t         out_q;
  logic                        load;
  logic                        at_last;

  // The output register takes a new beat when it is free or being drained.
  assign load      = cmd_valid_i && (!out_valid_q || pop_i);
  assign at_last   = (idx_q == cmd_i.last_idx);
  assign cmd_pop_o = load && at_last;

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cmd_i.slot[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= at_last ? '0 : idx_q + 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> idx_q <= cmd_i.last_idx)
    else $error("slot index runs past the end of the head command");

  a_term_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && cmd_i.slot[idx_q].last_of_name |-> at_last)
    else $error("terminator beat is not the final beat of its command");

  a_new_cmd_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> idx_q == '0)
    else $error("slot index not rewound after a command completes");

endmodule

/* tb/name_codec_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_codec_checker
// Watches the input, result and mode-write ports of the name escape codec,
// predicts every result beat from the accepted input beats and compares
// each result beat field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module name_codec_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic                push,
  input  logic                full,
  input  rnpc_pkg::in_item_t  in_item_i,
  input  logic                empty,
  input  logic                pop,
  input  rnpc_pkg::out_item_t out_item_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  localparam logic [4:0] HEX_BAD = 5'd16;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_phase_e;

  logic                mode;
  logic                at_start;
  esc_phase_e          esc_phase;
  logic [7:0]          held_digit;
  rnpc_pkg::out_item_t out_chars_q[$];
  rnpc_pkg::out_item_t want;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors_o++;
  endtask

  function automatic logic is_word_char(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b0, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b0, c[3:0] + 4'd9};
    return HEX_BAD;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
  endfunction

  task automatic emit(input logic [7:0] b, input logic v, input logic l);
    rnpc_pkg::out_item_t beat;
    beat.out_byte     = b;
    beat.byte_valid   = v;
    beat.last_of_name = l;
    out_chars_q.push_back(beat);
  endtask

  task automatic restart_name();
    at_start   = 1'b1;
    esc_phase  = ESC_IDLE;
    held_digit = 8'h00;
  endtask

  task automatic take_plain(input logic [7:0] b);
    if (b == rnpc_pkg::CH_PCT) begin
      esc_phase = ESC_PCT;
    end else begin
      emit(b, 1'b1, 1'b0);
    end
  endtask

  // Expands one accepted input beat into the result beats it must produce.
  task automatic codec_step(input rnpc_pkg::in_item_t it);
    logic [7:0] b;
    logic [4:0] lo;
    logic [4:0] hi;
    b  = it.in_byte;
    lo = hex_value(b);
    if (it.end_of_name) begin
      if (mode == rnpc_pkg::MODE_DECODE) begin
        if (esc_phase == ESC_PCT || esc_phase == ESC_DIGIT)
          emit(rnpc_pkg::CH_PCT, 1'b1, 1'b0);
        if (esc_phase == ESC_DIGIT) emit(held_digit, 1'b1, 1'b0);
      end
      emit(8'h00, 1'b0, 1'b1);
      restart_name();
    end else if (mode == rnpc_pkg::MODE_ENCODE) begin
      if (at_start) begin
        emit(rnpc_pkg::CH_HASH, 1'b1, 1'b0);
        at_start = 1'b0;
      end
      if (is_word_char(b)) begin
        emit(b, 1'b1, 1'b0);
      end else begin
        emit(rnpc_pkg::CH_PCT, 1'b1, 1'b0);
        emit(hex_digit(b[7:4]), 1'b1, 1'b0);
        emit(hex_digit(b[3:0]), 1'b1, 1'b0);
      end
    end else if (at_start && b == rnpc_pkg::CH_HASH) begin
      // A single leading hash is swallowed by the decoder.
      at_start = 1'b0;
    end else begin
      at_start = 1'b0;
      case (esc_phase)
        ESC_PCT: begin
          if (lo != HEX_BAD) begin
            held_digit = b;
            esc_phase  = ESC_DIGIT;
          end else begin
            emit(rnpc_pkg::CH_PCT, 1'b1, 1'b0);
            esc_phase = ESC_IDLE;
            take_plain(b);
          end
        end
        ESC_DIGIT: begin
          if (lo != HEX_BAD) begin
            hi = hex_value(held_digit);
            emit({hi[3:0], lo[3:0]}, 1'b1, 1'b0);
            esc_phase = ESC_IDLE;
          end else begin
            emit(rnpc_pkg::CH_PCT, 1'b1, 1'b0);
            emit(held_digit, 1'b1, 1'b0);
            esc_phase = ESC_IDLE;
            take_plain(b);
          end
          held_digit = 8'h00;
        end
        default: begin
          esc_phase = ESC_IDLE;
          take_plain(b);
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode     = rnpc_pkg::MODE_ENCODE;
      restart_name();
      out_chars_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (pop && !empty) begin
        if (out_chars_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing expected", out_item_i));
        end else begin
          want = out_chars_q.pop_front();
          if (out_item_i.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      out_item_i.out_byte, want.out_byte));
          if (out_item_i.byte_valid !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      out_item_i.byte_valid, want.byte_valid));
          if (out_item_i.last_of_name !== want.last_of_name)
            report_mismatch($sformatf("last_of_name %b, expected %b",
                                      out_item_i.last_of_name, want.last_of_name));
        end
      end
      // A mode write also starts a fresh name.
      if (cfg_we_i) begin
        mode = cfg_data_i;
        restart_name();
      end
      if (push && !full) codec_step(in_item_i);
      pending_o = out_chars_q.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives names through the escape codec in both modes, first with directed
// names covering the escape corner cases, then with random names under
// several sender and receiver idling patterns. The checker predicts and
// compares every result beat; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SEGMENT_BEATS = 9;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic                cfg_data;
  logic                push;
  logic                full;
  rnpc_pkg::in_item_t  in_item;
  logic                empty;
  logic                pop;
  rnpc_pkg::out_item_t out_item;
  int unsigned         errors;
  int unsigned         pending;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  bit                  hold_req;
  logic                mode_now;

  room_name_percent_codec u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  name_codec_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_i (out_item),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(negedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // Offers one beat after a random gap and returns right after the edge that takes it.
  task automatic offer(input logic [7:0] b, input logic eon);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{in_byte: b, end_of_name: eon};
    do begin
      @(negedge clk_i);
      took = !full;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) offer(s[i], 1'b0);
  endtask

  // Stops offering until every predicted beat has been taken, then lets the
  // pipeline settle, since swallowed bytes produce no result to wait for.
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    mode_now = m;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] random_hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  // Uniform bytes half of the time, escape-relevant characters otherwise.
  function automatic logic [7:0] noise_byte();
    string specials;
    specials = "%%%#09afAFgGzZ";
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return specials[$urandom_range(specials.len() - 1)];
  endfunction

  task automatic random_name(output int unsigned sent);
    int unsigned len;
    logic [7:0]  c;
    len  = $urandom_range(6);
    sent = 0;
    if (mode_now == rnpc_pkg::MODE_DECODE && $urandom_range(9) < 8) begin
      if ($urandom_range(1)) begin
        offer(rnpc_pkg::CH_HASH, 1'b0);
        sent++;
      end
      repeat (len) begin
        if ($urandom_range(2) == 0) begin
          offer(rnpc_pkg::CH_PCT, 1'b0);
          offer(random_hex_char(), 1'b0);
          offer(random_hex_char(), 1'b0);
          sent += 3;
        end else begin
          c = 8'($urandom_range(255));
          if (c == rnpc_pkg::CH_PCT) c = random_hex_char();
          offer(c, 1'b0);
          sent++;
        end
      end
    end else begin
      repeat (len) begin
        offer(noise_byte(), 1'b0);
        sent++;
      end
    end
    offer(8'($urandom_range(255)), 1'b1);
    sent++;
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned budget;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = 1'b0;
    push           = 1'b0;
    in_item        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    mode_now       = rnpc_pkg::MODE_ENCODE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Encode: zero byte, alphanumeric edges, neighbors, 0xff, empty name.
    offer(8'h00, 1'b0);
    send_text("9Az/[");
    offer(8'hFF, 1'b0);
    offer(8'hA5, 1'b1);
    offer(8'h5A, 1'b1);

    // Decode: leading hash, good escapes in both cases, both failed escapes,
    // and end of name in each escape phase.
    write_mode(rnpc_pkg::MODE_DECODE);
    send_text("#%41%aF%G%%3z%e");
    offer(8'h00, 1'b1);
    offer(8'h00, 1'b0);
    send_text("%");
    offer(8'hFF, 1'b1);
    offer(8'h00, 1'b1);
    // A mode write in the middle of an escape drops it.
    send_text("%4");
    write_mode(rnpc_pkg::MODE_DECODE);
    send_text("1");
    offer(8'h00, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int m = 0; m < 2; m++) begin
        write_mode((m == 0) ? rnpc_pkg::MODE_ENCODE : rnpc_pkg::MODE_DECODE);
        // Hold the receiver off while beats keep coming so the block backs up.
        if (ph == 0 && m == 0) hold_req = 1'b1;
        budget = 0;
        while (budget < SEGMENT_BEATS) begin
          random_name(n);
          budget += n;
        end
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
